### sv/key_record_validator_macros.svh
// Assertion macros shared by the key record validator RTL.
`ifndef KEY_RECORD_VALIDATOR_MACROS_SVH
`define KEY_RECORD_VALIDATOR_MACROS_SVH

// General property, sampled on clk and ignored while reset is asserted.
`define KRV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property that must hold whenever a result beat is offered.
`define KRV_ASSERT_OUT(lbl, cond, msg) \
  `KRV_ASSERT(lbl, out_valid |-> (cond), msg)

`endif

### sv/krv_pkg.sv
// Types, constants and the CRC step shared by the key record validator.
`timescale 1ns / 1ps

package krv_pkg;

  localparam int KEY_BYTES = 64;
  localparam int HDR_LEN   = 32;
  localparam int POS_W     = 13;

  localparam logic [POS_W-1:0] POS_MAX  = {POS_W{1'b1}};
  localparam logic [POS_W-1:0] REC_LEN  = POS_W'(HDR_LEN + KEY_BYTES);
  localparam logic [POS_W-1:0] REC_LAST = POS_W'(HDR_LEN + KEY_BYTES - 1);

  // Byte positions in the header.
  localparam logic [POS_W-1:0] POS_MAGIC_END   = POS_W'(3);
  localparam logic [POS_W-1:0] POS_VERSION_END = POS_W'(5);
  localparam logic [POS_W-1:0] POS_HSIZE_END   = POS_W'(7);
  localparam logic [POS_W-1:0] POS_KEYLEN_END  = POS_W'(23);
  localparam logic [POS_W-1:0] POS_CRC_START   = POS_W'(24);
  localparam logic [POS_W-1:0] POS_COMMIT      = POS_W'(28);
  localparam logic [POS_W-1:0] POS_COMMIT_END  = POS_W'(31);
  localparam logic [POS_W-1:0] POS_KEY_START   = POS_W'(HDR_LEN);

  // Word-aligned header fields, indexed by byte position divided by four.
  localparam logic [POS_W-3:0] WORD_GEN     = (POS_W-2)'(2);
  localparam logic [POS_W-3:0] WORD_KEY_ID  = (POS_W-2)'(3);
  localparam logic [POS_W-3:0] WORD_KEY_VER = (POS_W-2)'(4);
  localparam logic [POS_W-3:0] WORD_CRC     = (POS_W-2)'(6);

  localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT    = 32'hFFFF_FFFF;
  localparam logic [31:0] MAGIC_WORD  = 32'h4B46_544D;
  localparam logic [31:0] COMMIT_WORD = 32'h434D_5446;
  localparam logic [15:0] FMT_VERSION = 16'd1;
  localparam logic [15:0] HDR_SIZE    = 16'(HDR_LEN);
  localparam logic [31:0] KEY_LEN     = 32'(KEY_BYTES);

  localparam logic [3:0] FAIL_OK      = 4'd0;
  localparam logic [3:0] FAIL_MAGIC   = 4'd1;
  localparam logic [3:0] FAIL_VERSION = 4'd2;
  localparam logic [3:0] FAIL_HSIZE   = 4'd3;
  localparam logic [3:0] FAIL_KEYLEN  = 4'd4;
  localparam logic [3:0] FAIL_COMMIT  = 4'd5;
  localparam logic [3:0] FAIL_CRC     = 4'd6;
  localparam logic [3:0] FAIL_GEN     = 4'd7;
  localparam logic [3:0] FAIL_KEY_ID  = 4'd8;
  localparam logic [3:0] FAIL_LENGTH  = 4'd9;

  typedef struct packed {
    logic [7:0] data;
    logic       slot_b;
    logic       last;
  } krv_beat_t;

  typedef struct packed {
    logic        slot;
    logic        ok;
    logic [3:0]  fail_code;
    logic [31:0] generation;
    logic [31:0] key_id;
    logic [31:0] key_rev;
    logic        any_valid;
    logic        newest_slot;
  } krv_result_t;

  // One byte of a reflected CRC-32, least significant bit first.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
    logic [31:0] c;
    c = crc ^ {24'h0, data};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

### sv/krv_record_check.sv
// Per-record CRC, header capture, check sequence and slot store.
`timescale 1ns / 1ps

module krv_record_check (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 take,
  input  krv_pkg::krv_beat_t   beat,
  output krv_pkg::krv_result_t res
);
  import krv_pkg::*;

  logic [31:0]      crc_r, crc_nxt, crc_upd;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [3:0]       ff_r, ff_nxt, ff_upd;
  logic [31:0]      fs_r, fs_nxt, fs_upd;
  logic [31:0]      scrc_r, scrc_nxt, scrc_upd;
  logic [31:0]      gen_r, gen_nxt, gen_upd;
  logic [31:0]      kid_r, kid_nxt, kid_upd;
  logic [31:0]      kver_r, kver_nxt, kver_upd;
  logic [1:0]       sv_r, sv_nxt, sv_upd;
  logic [31:0]      sg_r [2];
  logic [31:0]      sg_nxt [2];
  logic [31:0]      sg_upd [2];

  logic             in_rec;
  logic [4:0]       lane;
  logic [POS_W-3:0] word;
  logic [3:0]       code;
  logic             ok;

  assign in_rec = pos_r < REC_LEN;
  assign lane   = {pos_r[1:0], 3'b000};
  assign word   = pos_r[POS_W-1:2];

  always_comb begin
    crc_upd  = crc_r;
    ff_upd   = ff_r;
    fs_upd   = fs_r;
    scrc_upd = scrc_r;
    gen_upd  = gen_r;
    kid_upd  = kid_r;
    kver_upd = kver_r;
    if (in_rec) begin
      fs_upd = {beat.data, fs_r[31:8]};
      if (pos_r < POS_CRC_START) begin
        crc_upd = crc_byte(crc_r, beat.data);
      end else if (pos_r < POS_COMMIT) begin
        // The stored CRC field is covered as if it were zero.
        crc_upd = crc_byte(crc_r, 8'h00);
      end else if (pos_r >= POS_KEY_START) begin
        crc_upd = crc_byte(crc_r, beat.data);
      end

      // Only the first failing header check is kept.
      if (ff_r == FAIL_OK) begin
        if (pos_r == POS_MAGIC_END && fs_upd != MAGIC_WORD) begin
          ff_upd = FAIL_MAGIC;
        end else if (pos_r == POS_VERSION_END && fs_upd[31:16] != FMT_VERSION) begin
          ff_upd = FAIL_VERSION;
        end else if (pos_r == POS_HSIZE_END && fs_upd[31:16] != HDR_SIZE) begin
          ff_upd = FAIL_HSIZE;
        end else if (pos_r == POS_KEYLEN_END && fs_upd != KEY_LEN) begin
          ff_upd = FAIL_KEYLEN;
        end else if (pos_r == POS_COMMIT_END && fs_upd != COMMIT_WORD) begin
          ff_upd = FAIL_COMMIT;
        end
      end

      // Header words are captured lane by lane, so a short record leaves
      // the bytes it never delivered at zero.
      if (word == WORD_GEN)     gen_upd[lane +: 8]  = beat.data;
      if (word == WORD_KEY_ID)  kid_upd[lane +: 8]  = beat.data;
      if (word == WORD_KEY_VER) kver_upd[lane +: 8] = beat.data;
      if (word == WORD_CRC)     scrc_upd[lane +: 8] = beat.data;
    end
  end

  always_comb begin
    priority if (pos_r != REC_LAST) begin
      code = FAIL_LENGTH;
    end else if (ff_upd != FAIL_OK) begin
      code = ff_upd;
    end else if (~crc_upd != scrc_upd) begin
      code = FAIL_CRC;
    end else if (gen_upd == 32'h0) begin
      code = FAIL_GEN;
    end else if (kid_upd == 32'h0) begin
      code = FAIL_KEY_ID;
    end else begin
      code = FAIL_OK;
    end
  end

  assign ok = (code == FAIL_OK);

  always_comb begin
    sv_upd    = sv_r;
    sg_upd[0] = sg_r[0];
    sg_upd[1] = sg_r[1];
    sv_upd[beat.slot_b] = ok;
    sg_upd[beat.slot_b] = gen_upd;
  end

  assign res.slot        = beat.slot_b;
  assign res.ok          = ok;
  assign res.fail_code   = code;
  assign res.generation  = gen_upd;
  assign res.key_id      = kid_upd;
  assign res.key_rev     = kver_upd;
  assign res.any_valid   = sv_upd[0] | sv_upd[1];
  assign res.newest_slot = sv_upd[1] & (~sv_upd[0] | (sg_upd[1] > sg_upd[0]));

  always_comb begin
    crc_nxt   = crc_r;
    pos_nxt   = pos_r;
    ff_nxt    = ff_r;
    fs_nxt    = fs_r;
    scrc_nxt  = scrc_r;
    gen_nxt   = gen_r;
    kid_nxt   = kid_r;
    kver_nxt  = kver_r;
    sv_nxt    = sv_r;
    sg_nxt[0] = sg_r[0];
    sg_nxt[1] = sg_r[1];
    if (take) begin
      if (beat.last) begin
        crc_nxt   = CRC_INIT;
        pos_nxt   = '0;
        ff_nxt    = FAIL_OK;
        fs_nxt    = '0;
        scrc_nxt  = '0;
        gen_nxt   = '0;
        kid_nxt   = '0;
        kver_nxt  = '0;
        sv_nxt    = sv_upd;
        sg_nxt[0] = sg_upd[0];
        sg_nxt[1] = sg_upd[1];
      end else begin
        crc_nxt  = crc_upd;
        pos_nxt  = (pos_r != POS_MAX) ? pos_r + POS_W'(1) : pos_r;
        ff_nxt   = ff_upd;
        fs_nxt   = fs_upd;
        scrc_nxt = scrc_upd;
        gen_nxt  = gen_upd;
        kid_nxt  = kid_upd;
        kver_nxt = kver_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r   <= CRC_INIT;
      pos_r   <= '0;
      ff_r    <= FAIL_OK;
      fs_r    <= '0;
      scrc_r  <= '0;
      gen_r   <= '0;
      kid_r   <= '0;
      kver_r  <= '0;
      sv_r    <= '0;
      sg_r[0] <= '0;
      sg_r[1] <= '0;
    end else begin
      crc_r   <= crc_nxt;
      pos_r   <= pos_nxt;
      ff_r    <= ff_nxt;
      fs_r    <= fs_nxt;
      scrc_r  <= scrc_nxt;
      gen_r   <= gen_nxt;
      kid_r   <= kid_nxt;
      kver_r  <= kver_nxt;
      sv_r    <= sv_nxt;
      sg_r[0] <= sg_nxt[0];
      sg_r[1] <= sg_nxt[1];
    end
  end

endmodule

### sv/key_record_validator.sv
// Top level of the key record validator: record checker and result buffer.
`timescale 1ns / 1ps
`include "key_record_validator_macros.svh"

// Takes a stored key record one byte per beat, with a byte-wide CRC-32 and
// header capture, so it sustains one input beat per clock while in_stall is
// low. The beat marked last yields one result beat, registered in the output
// register or, while that beat is held, in the skid register; every other
// beat yields none. Results pass through this two-entry buffer, so in_stall
// rises only when both entries hold results the receiver has not yet taken.
module key_record_validator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_record_byte,
  input  logic        in_slot_b,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_slot,
  output logic        out_record_ok,
  output logic [3:0]  out_fail_code,
  output logic [31:0] out_generation,
  output logic [31:0] out_key_id,
  output logic [31:0] out_key_rev,
  output logic        out_any_valid,
  output logic        out_newest_slot
);
  import krv_pkg::*;

  krv_beat_t   beat;
  krv_result_t res;
  krv_result_t out_r, out_nxt;
  krv_result_t skid_r, skid_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        skid_valid_r, skid_valid_nxt;
  logic        take, push, pop;

  assign beat.data   = in_record_byte;
  assign beat.slot_b = in_slot_b;
  assign beat.last   = in_last_byte;

  assign in_stall = skid_valid_r;
  assign take     = in_valid & ~skid_valid_r;
  assign push     = take & in_last_byte;
  assign pop      = out_valid_r & ~out_stall;

  krv_record_check u_check (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (take),
    .beat  (beat),
    .res   (res)
  );

  always_comb begin
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r;
    skid_nxt       = skid_r;
    skid_valid_nxt = skid_valid_r;
    if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_nxt       = res;
        skid_valid_nxt = push;
      end else begin
        out_nxt       = res;
        out_valid_nxt = push;
      end
    end else if (push) begin
      // The output beat is held, so the new result waits in the skid entry.
      skid_nxt       = res;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_slot        = out_r.slot;
  assign out_record_ok   = out_r.ok;
  assign out_fail_code   = out_r.fail_code;
  assign out_generation  = out_r.generation;
  assign out_key_id      = out_r.key_id;
  assign out_key_rev     = out_r.key_rev;
  assign out_any_valid   = out_r.any_valid;
  assign out_newest_slot = out_r.newest_slot;

  `KRV_ASSERT(a_skid_behind_out, in_stall |-> out_valid, "skid entry full with empty output")
  `KRV_ASSERT_OUT(a_ok_matches_code, out_record_ok == (out_fail_code == FAIL_OK), "ok flag and code disagree")
  `KRV_ASSERT_OUT(a_newest_needs_valid, out_any_valid || !out_newest_slot, "newest slot without valid slot")

endmodule
